[sv/qtc_pkg.sv]
// Package: shared types and constants for the quadratic trajectory cost block.
`timescale 1ns / 1ps
package qtc_pkg;
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;
  localparam logic [1:0] MAT_Q = 2'd0;
  localparam logic [1:0] MAT_R = 2'd1;
  localparam logic [1:0] MAT_S = 2'd2;
  localparam logic [1:0] MAT_T = 2'd3;
  localparam int NUM_TARGETS = 4;
  localparam int TARGET_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_3 = 2'd3;
  localparam int IN_DATA_W = 120;   // 119 payload bits padded to bytes
  localparam int OUT_DATA_W = 64;
  // Sum width: worst product 17*16*17 = 50 bits signed, 40 terms at the default sizes.
  localparam int SUM_W = 60;
endpackage

[sv/qtc_ram.sv]
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module qtc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 40
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule

[sv/quadratic_trajectory_cost.sv]
// Top level: quadratic trajectory cost accumulator.
`timescale 1ns / 1ps
// Timing: a gain load is written when accepted and the block stays ready. A
//   sample walks every gain entry in use, one gain RAM read per cycle: Q and
//   T are S by S, R and S are C by C (T only on the last sample), then it
//   drains through read, multiply, accumulate and saturate before the next
//   request is taken; on the last sample the total shows and holds input.
// Throughput: one sample at a time; the single gain RAM read port sets it.
// Reset: synchronous, active low; clears targets, trajectory state and the
//   handshake. The gain RAM is not cleared and must be loaded before use.
module quadratic_trajectory_cost #(
  parameter int STATE_SIZE = 4,
  parameter int CTRL_SIZE  = 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // tdata from bit 0: operation, gain_matrix[2], gain_row[2], gain_col[2],
  // gain_value[16], state_0..3[16 each], ctrl_0..1[16 each], zero pad
  input  logic [qtc_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                           in_tlast,    // last_sample
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [qtc_pkg::OUT_DATA_W-1:0] out_tdata,   // total_cost
  output logic                           out_tuser,   // cost_saturated
  input  logic                           cfg_we,
  input  logic [qtc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [qtc_pkg::TARGET_W-1:0]   cfg_data
);
  import qtc_pkg::*;

  localparam int QN = STATE_SIZE * STATE_SIZE;
  localparam int CN = CTRL_SIZE * CTRL_SIZE;
  localparam int R_BASE = QN;
  localparam int S_BASE = QN + CN;
  localparam int T_BASE = QN + 2 * CN;
  localparam int DEPTH = 2 * QN + 2 * CN;
  localparam int AW = $clog2(DEPTH);
  localparam int VN = (STATE_SIZE > CTRL_SIZE) ? STATE_SIZE : CTRL_SIZE;
  localparam int VW = (VN > 1) ? $clog2(VN) : 1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RUN  = 4'b0010,
    ST_DONE = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  // Pipeline tag that travels with each gain read.
  typedef struct packed {
    logic          vld;
    logic [1:0]    mat;
    logic [VW-1:0] row;
    logic [VW-1:0] col;
  } tag_t;

  state_t state_r, state_nxt;

  logic signed [15:0] target_r [NUM_TARGETS];
  logic signed [16:0] e_r  [VN];   // state error
  logic signed [16:0] u_r  [VN];   // control
  logic signed [16:0] du_r [VN];   // control change
  logic signed [15:0] prev_r [CTRL_SIZE];
  logic               first_r, sat_r, last_r;
  logic signed [63:0] acc_r;
  logic signed [SUM_W-1:0] sum_r;

  // Walk counters over the matrices of one sample.
  logic [1:0]    mat_r;
  logic [VW-1:0] row_r, col_r;
  tag_t          tag1_r, tag2_r;
  logic signed [33:0] vv_r;       // v_i * v_j
  logic signed [16:0] vj_r;
  logic signed [49:0] prod_r;
  logic               prod_vld_r;
  logic [2:0]         drain_r;

  // Unpack input fields.
  logic               f_op;
  logic [1:0]         f_mat, f_row, f_col;
  logic signed [15:0] f_gain;
  logic signed [15:0] f_state [4];
  logic signed [15:0] f_ctrl  [2];
  assign f_op   = in_tdata[0];
  assign f_mat  = in_tdata[2:1];
  assign f_row  = in_tdata[4:3];
  assign f_col  = in_tdata[6:5];
  assign f_gain = in_tdata[22:7];
  always_comb begin
    for (int k = 0; k < 4; k++) f_state[k] = in_tdata[23 + 16*k +: 16];
    for (int k = 0; k < 2; k++) f_ctrl[k]  = in_tdata[87 + 16*k +: 16];
  end

  logic in_fire, out_fire;
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_tvalid && out_tready;

  // Gain write address.
  logic          ld_ok;
  logic [AW-1:0] ld_addr;
  logic [31:0]   ld_n, ld_base;
  always_comb begin
    case (f_mat)
      MAT_Q:   begin ld_n = STATE_SIZE; ld_base = 0;      end
      MAT_R:   begin ld_n = CTRL_SIZE;  ld_base = R_BASE; end
      MAT_S:   begin ld_n = CTRL_SIZE;  ld_base = S_BASE; end
      default: begin ld_n = STATE_SIZE; ld_base = T_BASE; end
    endcase
    ld_ok = ({30'd0, f_row} < ld_n) && ({30'd0, f_col} < ld_n);
    ld_addr = AW'(ld_base + {30'd0, f_row} * ld_n + {30'd0, f_col});
  end

  // Read address of the walk.
  logic [31:0]   wk_n, wk_base;
  logic [AW-1:0] rd_addr;
  logic          wk_end_row, wk_end_mat;
  always_comb begin
    case (mat_r)
      MAT_Q:   begin wk_n = STATE_SIZE; wk_base = 0;      end
      MAT_R:   begin wk_n = CTRL_SIZE;  wk_base = R_BASE; end
      MAT_S:   begin wk_n = CTRL_SIZE;  wk_base = S_BASE; end
      default: begin wk_n = STATE_SIZE; wk_base = T_BASE; end
    endcase
    rd_addr = AW'(wk_base + {{(32-VW){1'b0}}, row_r} * wk_n + {{(32-VW){1'b0}}, col_r});
    wk_end_row = ({{(32-VW){1'b0}}, col_r} == wk_n - 1);
    wk_end_mat = wk_end_row && ({{(32-VW){1'b0}}, row_r} == wk_n - 1);
  end

  logic [15:0] rd_data;
  qtc_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_gain (
    .clk     (clk),
    .wr_en   (in_fire && f_op == OP_LOAD && ld_ok),
    .wr_addr (ld_addr),
    .wr_data (f_gain),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Vector element pick for the operand stage.
  logic signed [16:0] vi, vj;
  always_comb begin
    case (tag1_r.mat)
      MAT_R:   begin vi = u_r[tag1_r.row];  vj = u_r[tag1_r.col];  end
      MAT_S:   begin vi = du_r[tag1_r.row]; vj = du_r[tag1_r.col]; end
      default: begin vi = e_r[tag1_r.row];  vj = e_r[tag1_r.col];  end
    endcase
  end

  // Final shift and saturating add.
  logic signed [SUM_W-1:0] sh;
  logic signed [64:0]      wide;
  assign sh   = sum_r >>> 8;   // arithmetic shift floors
  assign wide = {acc_r[63], acc_r} + 65'(sh);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_fire && f_op == OP_SAMPLE) state_nxt = ST_RUN;
      ST_RUN:  if (wk_end_mat && (mat_r == MAT_T || (mat_r == MAT_S && !last_r)))
                 state_nxt = ST_DONE;
      ST_DONE: if (drain_r == 3'd4) state_nxt = last_r ? ST_OUT : ST_IDLE;
      ST_OUT:  if (out_fire) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      for (int k = 0; k < NUM_TARGETS; k++) target_r[k] <= '0;
      for (int k = 0; k < CTRL_SIZE; k++) prev_r[k] <= '0;
      first_r <= 1'b1;
      sat_r <= 1'b0;
      acc_r <= '0;
      tag1_r <= '0;
      tag2_r <= '0;
      prod_vld_r <= 1'b0;
      drain_r <= '0;
      out_tvalid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_TARGET_0: target_r[0] <= cfg_data;
          CFG_TARGET_1: target_r[1] <= cfg_data;
          CFG_TARGET_2: target_r[2] <= cfg_data;
          CFG_TARGET_3: target_r[3] <= cfg_data;
          default: ;
        endcase
      end
      // Capture a sample request.
      if (in_fire && f_op == OP_SAMPLE) begin
        for (int k = 0; k < VN; k++) begin
          e_r[k] <= (k < STATE_SIZE && k < 4)
                    ? 17'(f_state[k % 4]) - 17'(target_r[k % 4]) : '0;
          u_r[k] <= (k < CTRL_SIZE && k < 2) ? 17'(f_ctrl[k % 2]) : '0;
          du_r[k] <= (k < CTRL_SIZE && k < 2 && !first_r)
                    ? 17'(f_ctrl[k % 2]) - 17'(prev_r[k % CTRL_SIZE]) : '0;
        end
        for (int k = 0; k < CTRL_SIZE; k++)
          prev_r[k] <= (k < 2) ? f_ctrl[k % 2] : '0;
        first_r <= 1'b0;
        last_r <= in_tlast;
        mat_r <= MAT_Q;
        row_r <= '0;
        col_r <= '0;
        sum_r <= '0;
        drain_r <= '0;
      end
      // Advance the walk; tag follows the registered read.
      tag1_r.vld <= (state_r == ST_RUN);
      tag1_r.mat <= mat_r;
      tag1_r.row <= row_r;
      tag1_r.col <= col_r;
      if (state_r == ST_RUN) begin
        if (wk_end_mat) begin
          row_r <= '0;
          col_r <= '0;
          mat_r <= mat_r + 2'd1;
        end else if (wk_end_row) begin
          col_r <= '0;
          row_r <= row_r + 1'b1;
        end else begin
          col_r <= col_r + 1'b1;
        end
      end
      // Stage 2: v_i * v_j, gain held.
      tag2_r <= tag1_r;
      vv_r <= 34'(vi) * 34'(vj);
      vj_r <= 17'(signed'(rd_data));
      // Stage 3: times gain.
      prod_vld_r <= tag2_r.vld;
      prod_r <= 50'(vv_r) * 50'(vj_r);
      // Stage 4: accumulate exact sum.
      if (prod_vld_r) sum_r <= sum_r + SUM_W'(prod_r);
      if (state_r == ST_DONE) begin
        drain_r <= drain_r + 3'd1;
        if (drain_r == 3'd4) begin
          if (wide[64] != wide[63]) begin
            acc_r <= wide[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            sat_r <= 1'b1;
          end else begin
            acc_r <= wide[63:0];
          end
          if (last_r) out_tvalid <= 1'b1;
        end
      end
      if (state_r == ST_OUT && out_fire) begin
        out_tvalid <= 1'b0;
        acc_r <= '0;
        sat_r <= 1'b0;
        first_r <= 1'b1;
        for (int k = 0; k < CTRL_SIZE; k++) prev_r[k] <= '0;
      end
    end
  end

  assign out_tdata = acc_r;
  assign out_tuser = sat_r;
endmodule

[sv/qtc_checker.sv]
// Checker: port-level properties of the trajectory cost block, with bind.
`timescale 1ns / 1ps
module qtc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic [63:0] out_tdata,
  input logic out_tuser
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped while stalled");
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("request taken while a result waits");
  a_sat_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tuser))
    else $error("saturation flag changed while stalled");
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");
endmodule

bind quadratic_trajectory_cost qtc_checker u_qtc_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tuser(out_tuser)
);

[dv/quadratic_trajectory_cost_test.sv]
// Testbench: streams gain loads and trajectory samples through the cost block
// and checks each emitted total against an internal predictor.
`timescale 1ns / 1ps
module quadratic_trajectory_cost_test;
  import qtc_pkg::*;

  localparam int N_STATE = 4;
  localparam int N_CTRL  = 2;
  // Gain store layout: Q, R, S, T in that order
  localparam int Q_OFS = 0;
  localparam int R_OFS = N_STATE * N_STATE;
  localparam int S_OFS = R_OFS + N_CTRL * N_CTRL;
  localparam int T_OFS = S_OFS + N_CTRL * N_CTRL;
  localparam int GAIN_ENTRIES = T_OFS + N_STATE * N_STATE;
  // Allow drain after the last expected total
  localparam int DRAIN_CYCLES = 80;

  // Cost predictor: mirrors targets, gains and trajectory state, and holds
  // the totals still owed by the block.
  class cost_scoreboard;
    logic signed [15:0] target [N_STATE];
    logic signed [15:0] gain [GAIN_ENTRIES];
    logic signed [15:0] prev_ctrl [N_CTRL];
    longint acc;
    bit     first;
    bit     sat;
    longint owed_cost [$];
    bit     owed_sat [$];
    int     errors;

    function void clear_trajectory();
      foreach (prev_ctrl[i]) prev_ctrl[i] = '0;
      acc = 0;
      first = 1'b1;
      sat = 1'b0;
    endfunction

    function void set_target(int idx, logic [15:0] v);
      if (idx < N_STATE) target[idx] = v;
    endfunction

    function longint form(longint v[], int ofs, int n);
      longint s;
      s = 0;
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++)
          s += v[i] * longint'(gain[ofs + i * n + j]) * v[j];
      return s;
    endfunction

    // Note an accepted request: update the gain store or fold in one sample
    function void note_request(logic [IN_DATA_W-1:0] d, logic last);
      logic [1:0] m, r, c;
      int n, ofs;
      longint e[], u[], du[];
      longint smp;
      logic signed [64:0] t;
      m = d[2:1];
      r = d[4:3];
      c = d[6:5];
      if (d[0] == OP_LOAD) begin
        n = (m == MAT_R || m == MAT_S) ? N_CTRL : N_STATE;
        ofs = m == MAT_Q ? Q_OFS : m == MAT_R ? R_OFS : m == MAT_S ? S_OFS : T_OFS;
        if (r < n && c < n) gain[ofs + r * n + c] = d[22:7];
        return;
      end
      e = new[N_STATE];
      u = new[N_CTRL];
      du = new[N_CTRL];
      for (int i = 0; i < N_STATE; i++)
        e[i] = longint'($signed(d[23 + 16 * i +: 16])) - longint'(target[i]);
      for (int i = 0; i < N_CTRL; i++) begin
        u[i] = longint'($signed(d[87 + 16 * i +: 16]));
        du[i] = first ? 0 : u[i] - longint'(prev_ctrl[i]);
        prev_ctrl[i] = u[i][15:0];
      end
      first = 1'b0;
      smp = form(e, Q_OFS, N_STATE) + form(u, R_OFS, N_CTRL) + form(du, S_OFS, N_CTRL);
      if (last) smp += form(e, T_OFS, N_STATE);
      smp = smp >>> 8;  // floor to Q48.16
      t = 65'(signed'(acc)) + 65'(signed'(smp));
      if (t > 65'(signed'(64'h7fff_ffff_ffff_ffff))) begin
        acc = 64'h7fff_ffff_ffff_ffff;
        sat = 1'b1;
      end else if (t < 65'(signed'(64'h8000_0000_0000_0000))) begin
        acc = 64'h8000_0000_0000_0000;
        sat = 1'b1;
      end else begin
        acc = t[63:0];
      end
      if (last) begin
        owed_cost.push_back(acc);
        owed_sat.push_back(sat);
        clear_trajectory();
      end
    endfunction

    function void check_result(logic [63:0] cost, logic saturated);
      longint ec;
      bit es;
      if (owed_cost.size() == 0) begin
        $error("total_cost: no total expected, got %0d", $signed(cost));
        errors++;
        return;
      end
      ec = owed_cost.pop_front();
      es = owed_sat.pop_front();
      if (cost !== ec) begin
        $error("total_cost: expected %0d, got %0d", ec, $signed(cost));
        errors++;
      end
      if (saturated !== es) begin
        $error("cost_saturated: expected %0d, got %0d", es, saturated);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [TARGET_W-1:0]   cfg_data = '0;

  cost_scoreboard sb = new();
  int idle_pct;   // sender idle chance per request
  int stall_pct;  // receiver stall chance per cycle

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  quadratic_trajectory_cost u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Result side: check on every handshake, then pick the next stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Small values so totals stay readable, mixed with extremes and full range
  function automatic logic [15:0] pick16();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return {$urandom_range(1) ? 16'hffff : 16'h0000};
      3, 4: return 16'($urandom);
      default: return 16'($signed($urandom_range(2048)) - 1024);
    endcase
  endfunction

  // Send one request; an idle gap may come first, valid stays high otherwise
  task automatic send(input logic [IN_DATA_W-1:0] d, input logic last);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    sb.note_request(d, last);
  endtask

  task automatic load_gain(input logic [1:0] m, input logic [1:0] r, input logic [1:0] c,
                           input logic [15:0] v, input logic last);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[0] = OP_LOAD;
    d[2:1] = m;
    d[4:3] = r;
    d[6:5] = c;
    d[22:7] = v;
    d[IN_DATA_W-1:119] = '0;
    d[118:23] = {$urandom, $urandom, $urandom};  // don't-care payload on loads
    send(d, last);
  endtask

  task automatic sample(input logic [15:0] s0, s1, s2, s3, c0, c1, input logic last);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[0] = OP_SAMPLE;
    d[22:1] = 22'($urandom);  // gain fields are unused on samples
    d[118:23] = {c1, c0, s3, s2, s1, s0};
    send(d, last);
  endtask

  task automatic rand_sample(input logic last);
    sample(pick16(), pick16(), pick16(), pick16(), pick16(), pick16(), last);
  endtask

  // Fill all four matrices so that no unwritten entry is ever read
  task automatic load_all_gains();
    for (int m = 0; m < 4; m++)
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++)
          if (m == MAT_Q || m == MAT_T || (r < N_CTRL && c < N_CTRL))
            load_gain(2'(m), 2'(r), 2'(c), pick16(), 1'($urandom_range(1)));
  endtask

  // Let the block drain before touching registers
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.owed_cost.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_targets(input int mode);
    logic [15:0] v;
    for (int i = 0; i < NUM_TARGETS; i++) begin
      v = mode == 1 ? 16'h8000 : mode == 2 ? 16'h7fff : pick16();
      cfg_we    <= 1'b1;
      cfg_index <= i[CFG_IDX_W-1:0];
      cfg_data  <= v;
      sb.set_target(i, v);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic directed();
    load_all_gains();
    // Extreme gains on corner entries
    load_gain(MAT_Q, 0, 0, 16'h7fff, 1'b0);
    load_gain(MAT_T, 3, 3, 16'h8000, 1'b1);
    load_gain(MAT_R, 1, 1, 16'h8000, 1'b0);
    load_gain(MAT_S, 0, 1, 16'h7fff, 1'b0);
    // Out-of-size positions in R and S are dropped
    load_gain(MAT_R, 2, 0, 16'h1234, 1'b0);
    load_gain(MAT_S, 1, 3, 16'h4321, 1'b1);
    // Single-sample trajectory: no control change, terminal form added
    sample(16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h7fff, 16'h8000, 1'b1);
    // Two samples with largest control swing
    sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0);
    sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1'b1);
    // Gain change inside a trajectory
    sample(16'h0100, 16'hff00, 16'h0080, 16'h0000, 16'h0100, 16'h0000, 1'b0);
    load_gain(MAT_S, 0, 0, 16'h0200, 1'b0);
    sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
  endtask

  // Mostly well-formed trajectories, with stray loads in between
  task automatic random_traffic(input int items);
    int sent, len;
    sent = 0;
    while (sent < items) begin
      len = $urandom_range(4) == 0 ? $urandom_range(8, 16) : $urandom_range(1, 5);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(9) == 0) begin
          load_gain(2'($urandom), 2'($urandom), 2'($urandom), pick16(),
                    1'($urandom_range(1)));
          sent++;
        end
        rand_sample(k == len - 1);
        sent++;
      end
    end
  endtask

  initial begin
    idle_pct = 0;
    stall_pct = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 71; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 71; end
        default: begin idle_pct = 32; stall_pct = 32; end
      endcase
      write_targets(ph == 1 ? 1 : ph == 2 ? 2 : 0);
      if (ph == 0) directed();
      random_traffic(350);
      wait_idle();
    end
    if (sb.errors == 0 && sb.owed_cost.size() == 0) begin
      $display("PASS quadratic_trajectory_cost");
    end else begin
      $display("FAIL quadratic_trajectory_cost");
    end
    $finish;
  end

  // Hard stop if the block hangs
  initial begin
    #8000000;
    $display("FAIL quadratic_trajectory_cost");
    $finish;
  end

  initial sb.clear_trajectory();
  initial foreach (sb.target[i]) sb.target[i] = '0;
endmodule

[files.f]
sv/qtc_pkg.sv
sv/qtc_ram.sv
sv/quadratic_trajectory_cost.sv
sv/qtc_checker.sv
dv/quadratic_trajectory_cost_test.sv
